// ----- design/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants of the spectral flux accumulator
// Fixed point formats, datapath operation codes and the control and status
// bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sfa_pkg;

	// magnitude format: unsigned Q(32-F).F
	localparam int MAG_FRAC_BITS = 16;
	localparam int MAG_W         = 32;
	localparam int DIFF_W        = 33;
	localparam int SUM_W         = 48;
	localparam int PROD_W        = 2 * MAG_W;

	// log2 fraction bits produced by the squaring loop
	localparam int LOG_FRAC      = 20;
	localparam int CNT_W         = $clog2(LOG_FRAC);
	localparam int K_W           = $clog2(MAG_W);
	// log2 integer part (k - F) as signed, wide enough for any F in range
	localparam int KF_W          = K_W + 3;
	localparam int L2_W          = KF_W + LOG_FRAC;
	// ln 2 in Q.32
	localparam logic [MAG_W-1:0] LN2_Q32 = 32'd2977044472;
	// shift taking the Q.52 ln product back to F fraction bits
	localparam int LN_SHIFT      = LOG_FRAC + 32 - MAG_FRAC_BITS;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// flux modes
	localparam logic [1:0] MODE_GROWTH = 2'd1;
	localparam logic [1:0] MODE_DECAY  = 2'd2;

	// datapath operation codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
	localparam logic [OP_W-1:0] OP_SETUP   = 4'd2;
	localparam logic [OP_W-1:0] OP_NINIT   = 4'd3;
	localparam logic [OP_W-1:0] OP_NSHIFT  = 4'd4;
	localparam logic [OP_W-1:0] OP_SQUARE  = 4'd5;
	localparam logic [OP_W-1:0] OP_SQPOST  = 4'd6;
	localparam logic [OP_W-1:0] OP_LNMUL   = 4'd7;
	localparam logic [OP_W-1:0] OP_LNRND   = 4'd8;
	localparam logic [OP_W-1:0] OP_LNSTORE = 4'd9;
	localparam logic [OP_W-1:0] OP_RECT    = 4'd10;
	localparam logic [OP_W-1:0] OP_SQMUL   = 4'd11;
	localparam logic [OP_W-1:0] OP_ACC     = 4'd12;
	localparam logic [OP_W-1:0] OP_DPLAIN  = 4'd13;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} sfa_ctrl_t;

	typedef struct packed {
		logic x_zero;    // log operand is zero
		logic y_norm;    // mantissa top bit set
		logic cnt_more;  // squaring loop not yet on its last pass
		logic pass;      // second magnitude under way
		logic out_full;  // result register cannot take a beat
	} sfa_stat_t;

endpackage

// ----- design/spectral_flux_accumulator.sv -----
// ----------------------------------------------------------------------------
// spectral_flux_accumulator: per-bin spectral flux with frame total
// Takes one bin pair a beat, optionally in the log domain, rectifies the
// difference by mode and sums |diff| or diff squared over the frame.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tdata, s_tlast (last_bin)
//  m_*      out        m_tvalid / m_tready    m_tdata, m_tlast (frame_done)
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Log mode: each magnitude is normalised, put through twenty
//  square-and-test passes on the shared 32x32 multiplier, then scaled
//  and rounded; a zero magnitude skips straight to the store step.
//  Reset clears the configuration registers, the result valid flag, the running sum and the sequencer.
//  A result waiting on m_tready holds the sequencer at the accumulate step;
//  the next bin beat is taken while the previous result is still held.
//
module spectral_flux_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] current_mag, [63:32] earlier_mag
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [32:0] bin_diff, [80:33] flux_total, rest zero
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	localparam logic [1:0] REG_LOG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_FLUX_MODE     = 2'd1;
	localparam logic [1:0] REG_SQUARE_ENABLE = 2'd2;

	logic       log_enable_q;
	logic [1:0] flux_mode_q;
	logic       square_enable_q;

	sfa_pkg::sfa_ctrl_t ctrl;
	sfa_pkg::sfa_stat_t stat;

	logic signed [sfa_pkg::DIFF_W-1:0] bin_diff;
	logic [sfa_pkg::SUM_W-1:0]         flux_total;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_enable_q    <= 1'b0;
			flux_mode_q     <= 2'd0;
			square_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOG_ENABLE:    log_enable_q    <= cfg_data[0];
				REG_FLUX_MODE:     flux_mode_q     <= cfg_data;
				REG_SQUARE_ENABLE: square_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sfa_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.log_enable (log_enable_q),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	sfa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.flux_mode     (flux_mode_q),
		.square_enable (square_enable_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.current_mag   (s_tdata[31:0]),
		.earlier_mag   (s_tdata[63:32]),
		.last_bin      (s_tlast),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.bin_diff      (bin_diff),
		.frame_done    (m_tlast),
		.flux_total    (flux_total)
	);

	assign m_tdata = {7'b0, flux_total, bin_diff};

endmodule

// ----- design/sfa_sequencer.sv -----
// ----------------------------------------------------------------------------
// sfa_sequencer: microcode step counter and control store
// Steps through a small program; each control word names one datapath
// operation and an optional conditional jump.
// ----------------------------------------------------------------------------
module sfa_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                log_enable,
	input  sfa_pkg::sfa_stat_t  stat,
	output sfa_pkg::sfa_ctrl_t  ctrl
);

	localparam int STEP_W = 4;

	// jump conditions
	localparam logic [3:0] C_NEVER    = 4'd0;
	localparam logic [3:0] C_ALWAYS   = 4'd1;
	localparam logic [3:0] C_NO_IN    = 4'd2;
	localparam logic [3:0] C_LOG_OFF  = 4'd3;
	localparam logic [3:0] C_X_ZERO   = 4'd4;
	localparam logic [3:0] C_NOT_NORM = 4'd5;
	localparam logic [3:0] C_CNT_MORE = 4'd6;
	localparam logic [3:0] C_PASS_CLR = 4'd7;
	localparam logic [3:0] C_OUT_FULL = 4'd8;

	// program addresses
	localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
	localparam logic [STEP_W-1:0] ST_SETUP   = 4'd1;
	localparam logic [STEP_W-1:0] ST_NINIT   = 4'd2;
	localparam logic [STEP_W-1:0] ST_NSHIFT  = 4'd3;
	localparam logic [STEP_W-1:0] ST_SQUARE  = 4'd4;
	localparam logic [STEP_W-1:0] ST_SQPOST  = 4'd5;
	localparam logic [STEP_W-1:0] ST_LNMUL   = 4'd6;
	localparam logic [STEP_W-1:0] ST_LNRND   = 4'd7;
	localparam logic [STEP_W-1:0] ST_LNSTORE = 4'd8;
	localparam logic [STEP_W-1:0] ST_RECT    = 4'd9;
	localparam logic [STEP_W-1:0] ST_SQMUL   = 4'd10;
	localparam logic [STEP_W-1:0] ST_ACC     = 4'd11;
	localparam logic [STEP_W-1:0] ST_RET     = 4'd12;
	localparam logic [STEP_W-1:0] ST_DPLAIN  = 4'd13;

	typedef struct packed {
		logic [sfa_pkg::OP_W-1:0] op;
		logic [3:0]               cond;
		logic [STEP_W-1:0]        target;
	} sfa_uword_t;

	// control store
	function automatic sfa_uword_t ucode(input logic [STEP_W-1:0] addr);
		sfa_uword_t w;
		unique case (addr)
			ST_WAIT:    w = '{sfa_pkg::OP_LOAD,    C_NO_IN,    ST_WAIT};
			ST_SETUP:   w = '{sfa_pkg::OP_SETUP,   C_LOG_OFF,  ST_DPLAIN};
			ST_NINIT:   w = '{sfa_pkg::OP_NINIT,   C_X_ZERO,   ST_LNSTORE};
			ST_NSHIFT:  w = '{sfa_pkg::OP_NSHIFT,  C_NOT_NORM, ST_NSHIFT};
			ST_SQUARE:  w = '{sfa_pkg::OP_SQUARE,  C_NEVER,    ST_WAIT};
			ST_SQPOST:  w = '{sfa_pkg::OP_SQPOST,  C_CNT_MORE, ST_SQUARE};
			ST_LNMUL:   w = '{sfa_pkg::OP_LNMUL,   C_NEVER,    ST_WAIT};
			ST_LNRND:   w = '{sfa_pkg::OP_LNRND,   C_NEVER,    ST_WAIT};
			ST_LNSTORE: w = '{sfa_pkg::OP_LNSTORE, C_PASS_CLR, ST_NINIT};
			ST_RECT:    w = '{sfa_pkg::OP_RECT,    C_NEVER,    ST_WAIT};
			ST_SQMUL:   w = '{sfa_pkg::OP_SQMUL,   C_NEVER,    ST_WAIT};
			ST_ACC:     w = '{sfa_pkg::OP_ACC,     C_OUT_FULL, ST_ACC};
			ST_RET:     w = '{sfa_pkg::OP_NOP,     C_ALWAYS,   ST_WAIT};
			ST_DPLAIN:  w = '{sfa_pkg::OP_DPLAIN,  C_ALWAYS,   ST_RECT};
			default:    w = '{sfa_pkg::OP_NOP,     C_ALWAYS,   ST_WAIT};
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	sfa_uword_t        uw;
	logic              take;

	assign uw      = ucode(step_q);
	assign ctrl.op = uw.op;

	// evaluate the jump condition
	always_comb begin
		unique case (uw.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = !in_valid;
			C_LOG_OFF:  take = !log_enable;
			C_X_ZERO:   take = stat.x_zero;
			C_NOT_NORM: take = !stat.y_norm;
			C_CNT_MORE: take = stat.cnt_more;
			C_PASS_CLR: take = !stat.pass;
			C_OUT_FULL: take = stat.out_full;
			default:    take = 1'b0;
		endcase
	end

	// advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else if (take) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ----- design/sfa_datapath.sv -----
// ----------------------------------------------------------------------------
// sfa_datapath: operand registers, shared multiplier and accumulator
// Carries out one operation per cycle as the sequencer selects (held at
// accumulate while output is full): log by normalise and repeated squaring, differencing, rectify, square, sum.
// ----------------------------------------------------------------------------
module sfa_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sfa_pkg::sfa_ctrl_t                   ctrl,
	output sfa_pkg::sfa_stat_t                   stat,
	input  logic [1:0]                           flux_mode,
	input  logic                                 square_enable,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [sfa_pkg::MAG_W-1:0]            current_mag,
	input  logic [sfa_pkg::MAG_W-1:0]            earlier_mag,
	input  logic                                 last_bin,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sfa_pkg::DIFF_W-1:0]    bin_diff,
	output logic                                 frame_done,
	output logic [sfa_pkg::SUM_W-1:0]            flux_total
);

	localparam int W  = sfa_pkg::MAG_W;
	localparam int DW = sfa_pkg::DIFF_W;
	localparam int PW = sfa_pkg::PROD_W;
	localparam int SW = sfa_pkg::SUM_W;

	logic [W-1:0]                   cur_q, ear_q, x_q, y_q;
	logic                           last_q;
	logic [sfa_pkg::K_W-1:0]        k_q;
	logic [sfa_pkg::LOG_FRAC-1:0]   frac_q;
	logic [sfa_pkg::CNT_W-1:0]      cnt_q;
	logic                           pass_q, neg_q;
	logic signed [DW-1:0]           r_q, lnc_q, diff_q;
	logic [PW-1:0]                  p_q;
	logic [SW-1:0]                  sum_q;
	logic                           out_valid_q, out_last_q;
	logic signed [DW-1:0]           out_diff_q;
	logic [SW-1:0]                  out_total_q;

	logic                           load_fire, acc_fire;
	logic [W-1:0]                   ma, mb;
	logic [PW-1:0]                  prod;
	logic [W:0]                     sq_t;
	logic signed [sfa_pkg::KF_W-1:0] kf;
	logic signed [sfa_pkg::L2_W-1:0] l2;
	logic [sfa_pkg::L2_W-1:0]       l2_mag;
	logic [PW-1:0]                  ln_rnd;
	logic signed [DW-1:0]           ln_r;
	logic signed [DW-1:0]           diff_rect;
	logic [DW-1:0]                  diff_abs;
	logic [W-1:0]                   a_mag;
	logic [PW:0]                    sq_rnd;
	logic [PW-1:0]                  val;
	logic [PW:0]                    total;
	logic [SW-1:0]                  sat;

	assign in_ready  = (ctrl.op == sfa_pkg::OP_LOAD);
	assign load_fire = in_ready && in_valid;
	assign acc_fire  = (ctrl.op == sfa_pkg::OP_ACC) && !stat.out_full;

	assign stat.x_zero   = (x_q == '0);
	assign stat.y_norm   = y_q[W-1];
	assign stat.cnt_more = (cnt_q != sfa_pkg::CNT_W'(sfa_pkg::LOG_FRAC - 1));
	assign stat.pass     = pass_q;
	assign stat.out_full = out_valid_q && !out_ready;

	// log2 in Q.20: integer part k - F sits directly above the fraction
	assign kf     = $signed({3'b000, k_q}) - sfa_pkg::KF_W'(sfa_pkg::MAG_FRAC_BITS);
	assign l2     = {kf, frac_q};
	assign l2_mag = l2[sfa_pkg::L2_W-1] ? sfa_pkg::L2_W'(-l2) : sfa_pkg::L2_W'(l2);

	// pick multiplier operands
	always_comb begin
		case (ctrl.op)
			sfa_pkg::OP_SQUARE: begin
				ma = y_q;
				mb = y_q;
			end
			sfa_pkg::OP_LNMUL: begin
				ma = W'(l2_mag);
				mb = sfa_pkg::LN2_Q32;
			end
			default: begin
				ma = a_mag;
				mb = a_mag;
			end
		endcase
	end

	assign prod = ma * mb;

	// squared mantissa back to Q1.31, with the carry as the next log bit
	assign sq_t = p_q[PW-1:W-1];

	// ln rounded half away from zero
	assign ln_rnd = (p_q + (PW'(1) << (sfa_pkg::LN_SHIFT - 1))) >> sfa_pkg::LN_SHIFT;
	assign ln_r   = neg_q ? -DW'(ln_rnd) : DW'(ln_rnd);

	// rectify by mode
	always_comb begin
		diff_rect = diff_q;
		if (flux_mode == sfa_pkg::MODE_GROWTH && diff_q < 0) begin
			diff_rect = '0;
		end else if (flux_mode == sfa_pkg::MODE_DECAY && diff_q > 0) begin
			diff_rect = '0;
		end
	end

	assign diff_abs = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
	assign a_mag    = diff_abs[W-1:0];

	// term to add and saturating sum
	assign sq_rnd = {1'b0, p_q} + (PW+1)'(PW'(1) << (sfa_pkg::MAG_FRAC_BITS - 1));
	assign val    = square_enable ? PW'(sq_rnd >> sfa_pkg::MAG_FRAC_BITS) : PW'(a_mag);
	assign total  = {1'b0, val} + (PW+1)'(sum_q);
	assign sat    = (total >= (PW+1)'(sfa_pkg::SUM_MAX)) ? sfa_pkg::SUM_MAX : total[SW-1:0];

	// operand and working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			sfa_pkg::OP_LOAD: begin
				if (load_fire) begin
					cur_q  <= current_mag;
					ear_q  <= earlier_mag;
					last_q <= last_bin;
				end
			end
			sfa_pkg::OP_SETUP: begin
				x_q <= cur_q;
			end
			sfa_pkg::OP_NINIT: begin
				y_q    <= x_q;
				k_q    <= sfa_pkg::K_W'(W - 1);
				frac_q <= '0;
				cnt_q  <= '0;
				r_q    <= '0;
			end
			sfa_pkg::OP_NSHIFT: begin
				if (!y_q[W-1]) begin
					if (y_q[W-1:W-8] == '0) begin
						y_q <= y_q << 8;
						k_q <= k_q - sfa_pkg::K_W'(8);
					end else begin
						y_q <= y_q << 1;
						k_q <= k_q - 1'b1;
					end
				end
			end
			sfa_pkg::OP_SQUARE, sfa_pkg::OP_SQMUL: begin
				p_q <= prod;
			end
			sfa_pkg::OP_SQPOST: begin
				frac_q <= {frac_q[sfa_pkg::LOG_FRAC-2:0], sq_t[W]};
				y_q    <= sq_t[W] ? sq_t[W:1] : sq_t[W-1:0];
				cnt_q  <= cnt_q + 1'b1;
			end
			sfa_pkg::OP_LNMUL: begin
				p_q   <= prod;
				neg_q <= l2[sfa_pkg::L2_W-1];
			end
			sfa_pkg::OP_LNRND: begin
				r_q <= ln_r;
			end
			sfa_pkg::OP_LNSTORE: begin
				if (pass_q) begin
					diff_q <= lnc_q - r_q;
				end else begin
					lnc_q <= r_q;
					x_q   <= ear_q;
				end
			end
			sfa_pkg::OP_DPLAIN: begin
				diff_q <= $signed({1'b0, cur_q}) - $signed({1'b0, ear_q});
			end
			sfa_pkg::OP_RECT: begin
				diff_q <= diff_rect;
			end
			default: begin
			end
		endcase
	end

	// which magnitude the log unit is working on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (ctrl.op == sfa_pkg::OP_SETUP) begin
			pass_q <= 1'b0;
		end else if (ctrl.op == sfa_pkg::OP_LNSTORE) begin
			pass_q <= 1'b1;
		end
	end

	// running sum, cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (acc_fire) begin
			sum_q <= last_q ? '0 : sat;
		end
	end

	// result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_fire) begin
			out_diff_q  <= diff_q;
			out_last_q  <= last_q;
			out_total_q <= last_q ? sat : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign bin_diff   = out_diff_q;
	assign frame_done = out_last_q;
	assign flux_total = out_total_q;

endmodule
